### rtl/page_bitmap_block_allocator_core_macros.svh
// Assertion macros for the page bitmap block allocator checker.
// Included by the checker file only.
`ifndef PAGE_BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define PBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### rtl/pba_pkg.sv
// Package for the page bitmap block allocator: sizes, action and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pba_pkg;
   localparam int PAGE_BYTES   = 4096;
   localparam int HEADER_BYTES = 12;
   localparam int MAX_BLOCKS   = 1024;
   localparam int WORD_BITS    = 32;
   localparam int MAP_WORDS    = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W   = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W    = $clog2(WORD_BITS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W        = $clog2(MAX_BLOCKS) + 1;
   localparam int DIVW         = 16;

   localparam logic [1:0] ACT_FORMAT = 2'd0;
   localparam logic [1:0] ACT_ALLOC  = 2'd1;
   localparam logic [1:0] ACT_FREE   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_FREE  = 2'd2;

   localparam logic [11:0] RESET_BLOCK_SIZE = 12'd16;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] byte_offset;
   } req_type;

   typedef struct packed {
      logic [11:0]      block_offset;
      logic             is_full;
      logic             prev_full;
      logic             page_empty;
      logic [CNT_W-1:0] free_blocks;
      logic [1:0]       status;
   } rsp_type;
endpackage
`default_nettype wire

### rtl/pba_if.sv
// Valid/ready channel interfaces for requests, responses and the block size CSR.
// Depends on pba_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pba_req_if;
   logic              valid;
   logic              ready;
   pba_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pba_rsp_if;
   logic              valid;
   logic              ready;
   pba_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pba_csr_if;
   logic        valid;
   logic        ready;
   logic [11:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/page_bitmap_block_allocator_core.sv
// From the accepting edge to the response beat: format runs two 16-step divides, then
// a 32-word map sweep; alloc reads map words until a free bit shows, then updates it;
// free runs a divide, a map read and an update; an unused action responds directly.
// Throughput: one beat at a time; a new request is taken once the response beat leaves.
// The shared unit is a 16-step restoring divider, one quotient bit per cycle.
// Reset (synchronous) runs the format for block size 16 (253 free blocks).
`timescale 1ns / 1ps
`default_nettype none
module page_bitmap_block_allocator_core (
   input  wire logic    clock,
   input  wire logic    reset,
   pba_req_if.sink      req,
   pba_rsp_if.source    rsp,
   pba_csr_if.sink      csr
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_FMT2  = 4'd2;
   localparam logic [3:0] S_FMT3  = 4'd3;
   localparam logic [3:0] S_SWEEP = 4'd4;
   localparam logic [3:0] S_SCAN  = 4'd5;
   localparam logic [3:0] S_SCAN2 = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_FREE1 = 4'd8;
   localparam logic [3:0] S_FREE2 = 4'd9;
   localparam logic [3:0] S_RSP   = 4'd10;

   localparam int DIVW = pba_pkg::DIVW;
   localparam int CW   = pba_pkg::CNT_W;
   localparam int WW   = pba_pkg::WORD_IDX_W;
   localparam int BW   = pba_pkg::BIT_IDX_W;

   logic [31:0] map_mem [pba_pkg::MAP_WORDS];

   logic [3:0]       state_ff, state_in;
   logic [3:0]       ret_ff, ret_in;
   logic [11:0]      bsize_ff, bsize_in;
   logic [11:0]      held_ff, held_in;
   logic [CW-1:0]    free_ff, free_in;
   logic [CW-1:0]    total_ff, total_in;
   logic [DIVW-1:0]  num_ff, num_in;
   logic [DIVW-1:0]  rem_ff, rem_in;
   logic [DIVW-1:0]  quo_ff, quo_in;
   logic [4:0]       step_ff, step_in;
   logic [WW:0]      widx_ff, widx_in;
   logic [31:0]      rd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   pba_pkg::rsp_type rsp_ff, rsp_in;
   // Set while the post-reset format runs so that no response beat is made.
   logic             reset_run_ff, reset_run_in;

   logic            mem_we;
   logic [WW-1:0]   mem_waddr, mem_raddr;
   logic [31:0]     mem_wdata;
   logic [DIVW-1:0] rem_sh, trial;
   logic [BW-1:0]   low_bit;
   logic            low_any;
   logic [pba_pkg::IDX_W-1:0] idx;
   logic [11:0]     sat_size;
   logic [CW:0]     fill_lo;
   logic [31:0]     fill_word;
   logic [DIVW-1:0] tail;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // One restoring divide step on num_ff by held_ff.
   always_comb begin
      rem_sh = {rem_ff[DIVW-2:0], num_ff[DIVW-1]};
      trial  = rem_sh - {{(DIVW-12){1'b0}}, held_ff};
   end

   always_comb begin
      low_bit = '0;
      low_any = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (rd_ff[i]) begin
            low_bit = BW'(i);
            low_any = 1'b1;
         end
      end
   end

   always_comb begin
      sat_size = (bsize_ff < 12'd4) ? 12'd4 : (bsize_ff > 12'd2048) ? 12'd2048 : bsize_ff;
      // maxa is in quo_ff after the first divide; tail = ceil(maxa/32)*4 + header.
      tail = ((quo_ff + DIVW'(31)) >> 5 << 2) + DIVW'(pba_pkg::HEADER_BYTES);
      fill_lo = {1'b0, total_ff} - (CW+1)'({widx_ff[WW-1:0], 5'd0});
      if (fill_lo[CW] || fill_lo == '0)
         fill_word = '0;
      else if (fill_lo >= (CW+1)'(32))
         fill_word = '1;
      else
         fill_word = (32'd1 << fill_lo[4:0]) - 32'd1;
   end

   assign idx = quo_ff[pba_pkg::IDX_W-1:0];

   assign reset_run_in = (state_ff == S_SWEEP && widx_ff == (WW+1)'(pba_pkg::MAP_WORDS - 1)) ?
      1'b0 : reset_run_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      bsize_in     = csr.valid ? csr.data : bsize_ff;
      held_in      = held_ff;
      free_in      = free_ff;
      total_in     = total_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      widx_in      = widx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = widx_ff[WW-1:0];
      mem_wdata    = fill_word;
      mem_raddr    = widx_ff[WW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               rsp_in  = '0;
               rsp_in.free_blocks = free_ff;
               case (req.payload.action)
                  pba_pkg::ACT_FORMAT: begin
                     held_in  = sat_size;
                     num_in   = DIVW'(pba_pkg::PAGE_BYTES - pba_pkg::HEADER_BYTES);
                     rem_in   = '0;
                     step_in  = '0;
                     ret_in   = S_FMT2;
                     state_in = S_DIV;
                  end
                  pba_pkg::ACT_ALLOC: begin
                     widx_in  = '0;
                     state_in = S_SCAN;
                  end
                  pba_pkg::ACT_FREE: begin
                     num_in   = {{(DIVW-12){1'b0}}, req.payload.byte_offset};
                     rem_in   = '0;
                     step_in  = '0;
                     ret_in   = S_FREE1;
                     state_in = S_DIV;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_DIV: begin
            num_in  = {num_ff[DIVW-2:0], 1'b0};
            rem_in  = trial[DIVW-1] && !rem_sh[DIVW-1] ? rem_sh : trial;
            quo_in  = {quo_ff[DIVW-2:0], !(trial[DIVW-1] && !rem_sh[DIVW-1])};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(DIVW-1)) state_in = ret_ff;
         end
         S_FMT2: begin
            if (tail >= DIVW'(pba_pkg::PAGE_BYTES)) begin
               total_in = '0;
               state_in = S_FMT3;
            end else begin
               num_in   = DIVW'(pba_pkg::PAGE_BYTES) - tail;
               rem_in   = '0;
               step_in  = '0;
               ret_in   = S_FMT3;
               state_in = S_DIV;
            end
         end
         S_FMT3: begin
            if (ret_ff == S_FMT3)
               total_in = (quo_ff > DIVW'(pba_pkg::MAX_BLOCKS)) ?
                  CW'(pba_pkg::MAX_BLOCKS) : quo_ff[CW-1:0];
            ret_in   = S_IDLE;
            widx_in  = '0;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            mem_we  = 1'b1;
            widx_in = widx_ff + 1'b1;
            if (widx_ff == (WW+1)'(pba_pkg::MAP_WORDS - 1)) begin
               free_in            = total_ff;
               rsp_in.free_blocks = total_ff;
               rsp_valid_in       = !reset_run_ff;
               state_in           = S_IDLE;
            end
         end
         S_SCAN: begin
            state_in = S_SCAN2;
         end
         S_SCAN2: begin
            if (low_any) begin
               quo_in   = DIVW'({widx_ff[WW-1:0], low_bit});
               state_in = S_MUL;
            end else if (widx_ff == (WW+1)'(pba_pkg::MAP_WORDS - 1)) begin
               rsp_in.is_full = 1'b1;
               rsp_in.status  = pba_pkg::ST_FULL;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end else begin
               widx_in  = widx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_MUL: begin
            if (free_ff == '0 || {1'b0, idx} >= (pba_pkg::IDX_W+1)'(total_ff)) begin
               rsp_in.is_full = 1'b1;
               rsp_in.status  = pba_pkg::ST_FULL;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = rd_ff & ~(32'd1 << low_bit);
               free_in   = free_ff - 1'b1;
               rsp_in.block_offset = 12'(idx * held_ff);
               rsp_in.is_full      = (free_ff == CW'(1));
               rsp_in.free_blocks  = free_ff - 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_FREE1: begin
            widx_in   = (WW+1)'(idx >> 5);
            mem_raddr = idx[WW+BW-1:BW];
            state_in  = S_FREE2;
         end
         S_FREE2: begin
            if (quo_ff >= DIVW'(total_ff) || rd_ff[idx[BW-1:0]]) begin
               rsp_in.status = pba_pkg::ST_BAD_FREE;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = rd_ff | (32'd1 << idx[BW-1:0]);
               free_in   = free_ff + 1'b1;
               rsp_in.prev_full   = (free_ff == '0);
               rsp_in.page_empty  = (free_ff + 1'b1 == total_ff);
               rsp_in.free_blocks = free_ff + 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      rd_ff <= map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_DIV;
         ret_ff       <= S_FMT2;
         bsize_ff     <= pba_pkg::RESET_BLOCK_SIZE;
         held_ff      <= pba_pkg::RESET_BLOCK_SIZE;
         num_ff       <= DIVW'(pba_pkg::PAGE_BYTES - pba_pkg::HEADER_BYTES);
         rem_ff       <= '0;
         quo_ff       <= '0;
         step_ff      <= '0;
         free_ff      <= '0;
         total_ff     <= '0;
         widx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         reset_run_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         bsize_ff     <= bsize_in;
         held_ff      <= held_in;
         num_ff       <= num_in;
         rem_ff       <= rem_in;
         quo_ff       <= quo_in;
         step_ff      <= step_in;
         free_ff      <= free_in;
         total_ff     <= total_in;
         widx_ff      <= widx_in;
         rsp_valid_ff <= rsp_valid_in;
         reset_run_ff <= reset_run_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
   end
endmodule
`default_nettype wire

### rtl/pba_checker.sv
// Port-level checker for the page bitmap block allocator, bound to the top level.
// Depends on pba_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "page_bitmap_block_allocator_core_macros.svh"
module pba_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire pba_pkg::rsp_type  rsp_payload
);
   // A response beat never coexists with an open request slot.
   `PBA_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_valid, !req_ready, "ready while rsp held")
   // An accepted request blocks further requests next cycle.
   `PBA_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "not busy")
   // A full-page alloc always reports is_full with a zero block offset.
   `PBA_ASSERT_IMP(a_full_flags, clock, reset,
      rsp_valid && rsp_payload.status == pba_pkg::ST_FULL,
      rsp_payload.is_full && rsp_payload.block_offset == '0, "full status without flags")
   // A stalled response holds.
   `PBA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "rsp dropped")
endmodule

bind page_bitmap_block_allocator_core pba_checker u_pba_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
`default_nettype wire
